// ===== rtl/sts_pkg.sv =====
// Shared types, state codes and character-class functions for the token scanner.
// No dependencies; used by every module of the scanner and by its checker.
package sts_pkg;

    // Default sizes
    localparam int POS_BITS_DEFAULT    = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Result channel layout
    localparam int KIND_BITS  = 2;
    localparam int TYPE_BITS  = 5;
    localparam int OUT_BITS   = 16;
    localparam int TDATA_BITS = 40;

    // Result kinds
    localparam logic [KIND_BITS-1:0] KIND_TOKEN = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_ERROR = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_END   = 2'd2;

    // Automaton states; operator state for token code k is ST_OP0 + k
    localparam logic [4:0] ST_START  = 5'd0;
    localparam logic [4:0] ST_WS     = 5'd1;
    localparam logic [4:0] ST_NOT    = 5'd2;
    localparam logic [4:0] ST_DOT    = 5'd3;
    localparam logic [4:0] ST_OP0    = 5'd4;
    localparam logic [4:0] ST_LPAREN = 5'd4;
    localparam logic [4:0] ST_RPAREN = 5'd5;
    localparam logic [4:0] ST_LBRACE = 5'd6;
    localparam logic [4:0] ST_RBRACE = 5'd7;
    localparam logic [4:0] ST_LBRACK = 5'd8;
    localparam logic [4:0] ST_RBRACK = 5'd9;
    localparam logic [4:0] ST_EQEQ   = 5'd10;
    localparam logic [4:0] ST_NE     = 5'd11;
    localparam logic [4:0] ST_LT     = 5'd12;
    localparam logic [4:0] ST_LE     = 5'd13;
    localparam logic [4:0] ST_GT     = 5'd14;
    localparam logic [4:0] ST_GE     = 5'd15;
    localparam logic [4:0] ST_PLUS   = 5'd16;
    localparam logic [4:0] ST_MINUS  = 5'd17;
    localparam logic [4:0] ST_STAR   = 5'd18;
    localparam logic [4:0] ST_SLASH  = 5'd19;
    localparam logic [4:0] ST_PCT    = 5'd20;
    localparam logic [4:0] ST_COMMA  = 5'd21;
    localparam logic [4:0] ST_SEMI   = 5'd22;
    localparam logic [4:0] ST_ASSIGN = 5'd23;
    localparam logic [4:0] ST_ID     = 5'd24;
    localparam logic [4:0] ST_NUM    = 5'd25;
    localparam logic [4:0] ST_NUMD   = 5'd26;
    localparam logic [4:0] ST_DEAD   = 5'd30;
    localparam logic [4:0] ST_NONE   = 5'd31;

    // Token types
    localparam logic [TYPE_BITS-1:0] TYPE_ID     = 5'd20;
    localparam logic [TYPE_BITS-1:0] TYPE_NUMBER = 5'd21;
    localparam logic [TYPE_BITS-1:0] TYPE_NONE   = 5'd0;
    localparam logic [TYPE_BITS-1:0] TYPE_FUNC   = 5'd22;
    localparam logic [TYPE_BITS-1:0] TYPE_TRUE   = 5'd23;
    localparam logic [TYPE_BITS-1:0] TYPE_FALSE  = 5'd24;
    localparam logic [TYPE_BITS-1:0] TYPE_FOR    = 5'd25;
    localparam logic [TYPE_BITS-1:0] TYPE_WHILE  = 5'd26;
    localparam logic [TYPE_BITS-1:0] TYPE_IF     = 5'd27;
    localparam logic [TYPE_BITS-1:0] TYPE_ELSE   = 5'd28;
    localparam logic [TYPE_BITS-1:0] TYPE_VAR    = 5'd29;
    localparam logic [TYPE_BITS-1:0] TYPE_RETURN = 5'd30;
    localparam logic [TYPE_BITS-1:0] TYPE_NULL   = 5'd31;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Packed identifier prefix, first character highest
    localparam logic [47:0] PREFIX_FULL = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] KW_FUNC   = 48'h0000_6675_6E63;
    localparam logic [47:0] KW_TRUE   = 48'h0000_7472_7565;
    localparam logic [47:0] KW_FALSE  = 48'h0066_616C_7365;
    localparam logic [47:0] KW_FOR    = 48'h0000_0066_6F72;
    localparam logic [47:0] KW_WHILE  = 48'h0077_6869_6C65;
    localparam logic [47:0] KW_IF     = 48'h0000_0000_6966;
    localparam logic [47:0] KW_ELSE   = 48'h0000_656C_7365;
    localparam logic [47:0] KW_VAR    = 48'h0000_0076_6172;
    localparam logic [47:0] KW_RETURN = 48'h7265_7475_726E;
    localparam logic [47:0] KW_NULL   = 48'h0000_6E75_6C6C;

    // One result as it leaves the scanner
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [TYPE_BITS-1:0] ttype;
        logic [OUT_BITS-1:0]  start;
        logic [OUT_BITS-1:0]  len;
    } result_t;

    // Results caused by one character; r1 only counts when two is set
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    function automatic result_t mk_result(logic [KIND_BITS-1:0] kind,
                                          logic [TYPE_BITS-1:0] ttype,
                                          logic [OUT_BITS-1:0] start,
                                          logic [OUT_BITS-1:0] len);
        result_t r;
        r.kind  = kind;
        r.ttype = ttype;
        r.start = start;
        r.len   = len;
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
    endfunction

    function automatic logic accepting(logic [4:0] s);
        return (s == ST_WS) || ((s >= ST_OP0) && (s <= ST_NUMD));
    endfunction

    // Transition out of the start state
    function automatic logic [4:0] start_next(logic [7:0] c);
        logic [4:0] t;
        case (c)
            CH_LPAREN: t = ST_LPAREN;
            CH_RPAREN: t = ST_RPAREN;
            CH_LBRACE: t = ST_LBRACE;
            CH_RBRACE: t = ST_RBRACE;
            CH_LBRACK: t = ST_LBRACK;
            CH_RBRACK: t = ST_RBRACK;
            CH_LT:     t = ST_LT;
            CH_GT:     t = ST_GT;
            CH_PLUS:   t = ST_PLUS;
            CH_MINUS:  t = ST_MINUS;
            CH_STAR:   t = ST_STAR;
            CH_SLASH:  t = ST_SLASH;
            CH_PCT:    t = ST_PCT;
            CH_COMMA:  t = ST_COMMA;
            CH_SEMI:   t = ST_SEMI;
            CH_EQ:     t = ST_ASSIGN;
            CH_BANG:   t = ST_NOT;
            CH_AMP:    t = ST_DEAD;
            CH_BAR:    t = ST_DEAD;
            default: begin
                if (is_digit(c))       t = ST_NUM;
                else if (is_letter(c)) t = ST_ID;
                else if (is_space(c))  t = ST_WS;
                else                   t = ST_NONE;
            end
        endcase
        return t;
    endfunction

    // Full automaton transition
    function automatic logic [4:0] next_state(logic [4:0] s, logic [7:0] c);
        logic [4:0] t;
        case (s)
            ST_START: t = start_next(c);
            ST_WS:    t = is_space(c) ? ST_WS : ST_NONE;
            ST_ID:    t = (is_letter(c) || is_digit(c)) ? ST_ID : ST_NONE;
            ST_NUM: begin
                if (is_digit(c))       t = ST_NUM;
                else if (is_letter(c)) t = ST_DEAD;
                else if (c == CH_DOT)  t = ST_DOT;
                else                   t = ST_NONE;
            end
            ST_DOT, ST_NUMD: begin
                if (is_digit(c))       t = ST_NUMD;
                else if (is_letter(c)) t = ST_DEAD;
                else                   t = ST_NONE;
            end
            ST_NOT:    t = (c == CH_EQ) ? ST_NE : ST_NONE;
            ST_ASSIGN: t = (c == CH_EQ) ? ST_EQEQ : ST_NONE;
            ST_LT:     t = (c == CH_EQ) ? ST_LE : ST_NONE;
            ST_GT:     t = (c == CH_EQ) ? ST_GE : ST_NONE;
            ST_SLASH:  t = (c == CH_SLASH) ? ST_DEAD : ST_NONE;
            default:   t = ST_NONE;
        endcase
        return t;
    endfunction

    // Token type of a finished accepting state
    function automatic logic [TYPE_BITS-1:0] token_type_of(logic [4:0] s, logic [47:0] pref);
        logic [TYPE_BITS-1:0] ty;
        if (s == ST_ID) begin
            if (pref == KW_FUNC)        ty = TYPE_FUNC;
            else if (pref == KW_TRUE)   ty = TYPE_TRUE;
            else if (pref == KW_FALSE)  ty = TYPE_FALSE;
            else if (pref == KW_FOR)    ty = TYPE_FOR;
            else if (pref == KW_WHILE)  ty = TYPE_WHILE;
            else if (pref == KW_IF)     ty = TYPE_IF;
            else if (pref == KW_ELSE)   ty = TYPE_ELSE;
            else if (pref == KW_VAR)    ty = TYPE_VAR;
            else if (pref == KW_RETURN) ty = TYPE_RETURN;
            else if (pref == KW_NULL)   ty = TYPE_NULL;
            else                        ty = TYPE_ID;
        end else if ((s == ST_NUM) || (s == ST_NUMD)) begin
            ty = TYPE_NUMBER;
        end else begin
            ty = s - ST_OP0;
        end
        return ty;
    endfunction

endpackage

// ===== rtl/sts_front.sv =====
// Scanner front part: takes one character per transfer, steps the automaton and
// queues the results that character causes. Depends on sts_pkg.
module sts_front #(
    parameter int POS_BITS = sts_pkg::POS_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] ch
    input  sts_pkg::q_status_t q_status,
    output logic              q_push,
    output sts_pkg::entry_t   q_entry
);
    import sts_pkg::*;

    localparam int EXT_BITS = (POS_BITS > OUT_BITS) ? POS_BITS : OUT_BITS;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // Saturate a position or length to the output width
    function automatic logic [OUT_BITS-1:0] sat_out(logic [POS_BITS-1:0] v);
        logic [EXT_BITS-1:0] ve;
        ve = EXT_BITS'(v);
        return (ve > EXT_BITS'(17'h0FFFF)) ? {OUT_BITS{1'b1}} : ve[OUT_BITS-1:0];
    endfunction

    logic [4:0]          scan_state_reg, scan_state_next;
    logic [POS_BITS-1:0] position_reg, position_next;
    logic [POS_BITS-1:0] token_begin_reg, token_begin_next;
    logic [47:0]         prefix_reg, prefix_next;
    logic                aborted_reg, aborted_next;

    logic                accept;
    logic [7:0]          c;
    logic [4:0]          s, t, t2, enter_state;
    logic [POS_BITS-1:0] p, tb, p_inc, err_len;
    logic [47:0]         pref, pref_add;
    logic                err_case, do_enter;
    logic                a_v, b_v;
    result_t             a_r, b_r;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;

    // Automaton step and result selection
    always_comb begin
        s        = scan_state_reg;
        p        = position_reg;
        p_inc    = (p == POS_MAX) ? p : p + POS_BITS'(1);
        tb       = (s == ST_START) ? p : token_begin_reg;
        pref     = (s == ST_START) ? 48'd0 : prefix_reg;
        t        = (c == CH_NUL) ? ST_NONE : next_state(s, c);
        t2       = start_next(c);
        err_len  = p - tb + POS_BITS'(((p != POS_MAX) || (p == tb)) ? 1 : 0);
        err_case = (t == ST_DEAD) ||
                   ((t == ST_NONE) && !accepting(s) && !((s == ST_START) && (c == CH_NUL)));

        a_v = 1'b0;
        a_r = mk_result(KIND_TOKEN, TYPE_NONE, '0, '0);
        b_v = 1'b0;
        b_r = mk_result(KIND_END, TYPE_NONE, sat_out(p), '0);

        scan_state_next  = scan_state_reg;
        position_next    = position_reg;
        token_begin_next = token_begin_reg;
        prefix_next      = prefix_reg;
        aborted_next     = aborted_reg;
        do_enter         = 1'b0;
        enter_state      = t;

        if (aborted_reg) begin
            // drop characters until the terminator
            if (c == CH_NUL) begin
                b_v = 1'b1;
            end
        end else if (err_case) begin
            a_v = 1'b1;
            a_r = mk_result(KIND_ERROR, TYPE_NONE, sat_out(tb), sat_out(err_len));
            token_begin_next = tb;
            prefix_next      = pref;
            if (c == CH_NUL) begin
                b_v = 1'b1;
            end else begin
                aborted_next  = 1'b1;
                position_next = p_inc;
            end
        end else if (t != ST_NONE) begin
            token_begin_next = tb;
            prefix_next      = pref;
            do_enter         = 1'b1;
        end else begin
            // no transition: finish the pending token, then rescan from start
            if ((s != ST_START) && (s != ST_WS)) begin
                a_v = 1'b1;
                a_r = mk_result(KIND_TOKEN, token_type_of(s, pref), sat_out(tb),
                                sat_out(p - tb));
            end
            scan_state_next  = ST_START;
            token_begin_next = p;
            prefix_next      = 48'd0;
            if (c == CH_NUL) begin
                b_v = 1'b1;
            end else if ((t2 == ST_NONE) || (t2 == ST_DEAD)) begin
                b_v           = 1'b1;
                b_r           = mk_result(KIND_ERROR, TYPE_NONE, sat_out(p), 16'd1);
                aborted_next  = 1'b1;
                position_next = p_inc;
            end else begin
                do_enter    = 1'b1;
                enter_state = t2;
            end
        end

        // enter a new state on this character
        pref_add = (prefix_next[47:40] != 8'd0) ? PREFIX_FULL : {prefix_next[39:0], c};
        if (do_enter) begin
            scan_state_next = enter_state;
            position_next   = p_inc;
            if (enter_state == ST_ID) begin
                prefix_next = pref_add;
            end
        end

        // terminator starts a new text
        if ((c == CH_NUL) && b_v && (b_r.kind == KIND_END)) begin
            scan_state_next  = ST_START;
            position_next    = '0;
            token_begin_next = '0;
            prefix_next      = 48'd0;
            aborted_next     = 1'b0;
        end

        // pack results in order
        q_entry.two = a_v && b_v;
        q_entry.r0  = a_v ? a_r : b_r;
        q_entry.r1  = b_r;
        q_push      = accept && (a_v || b_v);
    end

    // Scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_state_reg  <= ST_START;
            position_reg    <= '0;
            token_begin_reg <= '0;
            prefix_reg      <= 48'd0;
            aborted_reg     <= 1'b0;
        end else if (accept) begin
            scan_state_reg  <= scan_state_next;
            position_reg    <= position_next;
            token_begin_reg <= token_begin_next;
            prefix_reg      <= prefix_next;
            aborted_reg     <= aborted_next;
        end
    end

endmodule

// ===== rtl/sts_queue.sv =====
// Short queue of result entries between the scanner front and back parts.
// Depends on sts_pkg.
module sts_queue #(
    parameter int DEPTH = sts_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  sts_pkg::entry_t    push_entry,
    input  logic               pop,
    output sts_pkg::entry_t    head_entry,
    output sts_pkg::q_status_t status
);
    import sts_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    entry_t        slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign status.full      = (count_reg == CW'(DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign do_push          = push && !status.full;
    assign do_pop           = pop && status.not_empty;
    assign head_entry       = slots[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/sts_back.sv =====
// Scanner back part: splits queued entries into single results and holds them
// in the output register until transfer. Depends on sts_pkg.
module sts_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sts_pkg::q_status_t             q_status,
    input  sts_pkg::entry_t                head_entry,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sts_pkg::TDATA_BITS-1:0] m_tdata,  // [4:0] token_type, [20:5] token_start,
                                                     // [36:21] token_length, [39:37] zero
    output logic [sts_pkg::KIND_BITS-1:0]  m_tuser,  // [1:0] kind
    output logic                           m_tlast
);
    import sts_pkg::*;

    logic    out_valid_reg, hold_valid_reg, out_last_reg;
    result_t out_res_reg, hold_res_reg;
    logic    load;

    assign load  = !out_valid_reg || m_tready;
    assign q_pop = load && !hold_valid_reg && q_status.not_empty;

    // Control: output valid and pending second result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else if (load) begin
            if (hold_valid_reg) begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end else if (q_status.not_empty) begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= head_entry.two;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load) begin
            if (hold_valid_reg) begin
                out_res_reg  <= hold_res_reg;
                out_last_reg <= 1'b1;
            end else if (q_status.not_empty) begin
                out_res_reg  <= head_entry.r0;
                out_last_reg <= !head_entry.two;
                hold_res_reg <= head_entry.r1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_res_reg.len, out_res_reg.start, out_res_reg.ttype};

endmodule

// ===== rtl/script_token_scanner_core.sv =====
// Token scanner: one character per cycle in; the results of a character are written to the
// queue on its input transfer, then loaded into the output register.
// Throughput is one character per cycle while the queue has room; each result needs its
// own output transfer, so a character ending one token and starting a failing one needs two.
// The queue of QUEUE_DEPTH entries lets input continue while output stalls.
// Reset (aresetn low, synchronous) returns the scanner to the start state at position 0.
module script_token_scanner_core #(
    parameter int POS_BITS    = sts_pkg::POS_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = sts_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [7:0] ch
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sts_pkg::TDATA_BITS-1:0] m_tdata,  // [4:0] token_type, [20:5] token_start,
                                                     // [36:21] token_length, [39:37] zero
    output logic [sts_pkg::KIND_BITS-1:0]  m_tuser,  // [1:0] kind
    output logic                           m_tlast
);
    import sts_pkg::*;

    q_status_t q_status;
    entry_t    push_entry, head_entry;
    logic      q_push, q_pop;

    sts_front #(.POS_BITS(POS_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    sts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    sts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_status   (q_status),
        .head_entry (head_entry),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== rtl/sts_checker.sv =====
// Port-level checks on the token scanner result channel, bound to the top level.
// Depends on sts_pkg and script_token_scanner_core.
module sts_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sts_pkg::TDATA_BITS-1:0] m_tdata,
    input logic [sts_pkg::KIND_BITS-1:0]  m_tuser,
    input logic                           m_tlast
);
    import sts_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // end of text is always the final result of its character
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_END) |-> m_tlast)
        else $error("end result not marked last");

    // end result carries no type and no length
    a_end_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_END) |-> (m_tdata[4:0] == TYPE_NONE)
                                              && (m_tdata[36:21] == 16'd0))
        else $error("end result fields not zero");

    // an error covers at least the offending character
    a_err_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ERROR) |-> (m_tdata[4:0] == TYPE_NONE)
                                                && (m_tdata[36:21] != 16'd0))
        else $error("error result malformed");

endmodule

bind script_token_scanner_core sts_checker u_sts_checker (.*);
